// ===== rtl/tdma_pkg.sv =====
// tdma_pkg: shared types and constants for the tdma slot transmit scheduler
// used by tdma_step, tdma_slot_transmit_scheduler and tdma_checker; no dependencies
package tdma_pkg;

    localparam logic [7:0]  NODE_ID_MAX       = 8'd15;
    localparam logic [3:0]  NODE_ID_RESET     = 4'd1;
    localparam logic [15:0] AUTO_PERIOD_RESET = 16'd3000;
    localparam logic [17:0] SINCE_BEACON_MAX  = 18'h3FFFF;
    localparam logic [16:0] SINCE_SEND_MAX    = 17'h1FFFF;
    localparam logic [17:0] LOSS_CYCLES       = 18'd3;

    // register index, taken from paddr[2]
    localparam logic REG_NODE_ID     = 1'b0;
    localparam logic REG_AUTO_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SLOT = 2'd1,
        KIND_OUT  = 2'd2,
        KIND_AUTO = 2'd3
    } send_kind_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] beacon_slot_ms;
        logic [15:0] beacon_cycle_ms;
        logic [7:0]  beacon_max_slot;
        logic [8:0]  jitter_sync;
        logic [8:0]  jitter_auto;
    } item_t;

    typedef struct packed {
        logic        synced;
        logic        sent_this_cycle;
        logic [15:0] slot_len;
        logic [15:0] cycle_len;
        logic [7:0]  last_slot;
        logic [17:0] since_beacon;
        logic [16:0] since_send;
    } sched_state_t;

    typedef struct packed {
        logic       send_now;
        send_kind_t send_kind;
        logic       is_synced;
    } result_t;

endpackage

// ===== rtl/tdma_slot_transmit_scheduler.sv =====
// tdma_slot_transmit_scheduler: beacon-synchronized tdma transmit scheduler, top level
// depends on tdma_pkg and tdma_step
//
// channel  dir  handshake          payload
// s_       in   s_valid/s_ready    kind, beacon_slot_ms, beacon_cycle_ms, beacon_max_slot,
//                                  jitter_sync, jitter_auto
// m_       out  m_valid/m_ready    send_now, send_kind, is_synced
// apb      in   psel/penable       paddr[2] selects node_id (0x0) or auto_period_ms (0x4)
//
// one request per cycle sustained while m_ready holds; each tick passes through the input
// register and then the result register
// the id * slot_len multiply and the slot-fit compare set the register-to-register path
// aresetn is synchronous and active low; it clears schedule state and the valid flags
// and loads the config defaults; a stalled result holds the result register, and an empty
// input register still takes one more request, then s_ready drops until m_ready returns
module tdma_slot_transmit_scheduler import tdma_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [15:0] s_beacon_slot_ms,
    input  logic [15:0] s_beacon_cycle_ms,
    input  logic [7:0]  s_beacon_max_slot,
    input  logic [8:0]  s_jitter_sync,
    input  logic [8:0]  s_jitter_auto,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_send_now,
    output logic [1:0]  m_send_kind,
    output logic        m_is_synced,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [3:0]   node_id_reg;
    logic [15:0]  auto_period_reg;

    // input stage
    logic         in_valid_reg, in_valid_next;
    item_t        in_item_reg;

    // schedule state, updated as each tick leaves the input stage
    sched_state_t state_reg, state_next;

    // result stage
    logic         out_valid_reg, out_valid_next;
    result_t      out_res_reg, step_res;

    logic         advance;
    logic         cfg_write;

    // tick moves on when the result register is free or being drained
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tdma_step u_step (
        .node_id        (node_id_reg),
        .auto_period_ms (auto_period_reg),
        .cur            (state_reg),
        .item           (in_item_reg),
        .nxt            (state_next),
        .res            (step_res)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.kind            <= s_kind;
            in_item_reg.beacon_slot_ms  <= s_beacon_slot_ms;
            in_item_reg.beacon_cycle_ms <= s_beacon_cycle_ms;
            in_item_reg.beacon_max_slot <= s_beacon_max_slot;
            in_item_reg.jitter_sync     <= s_jitter_sync;
            in_item_reg.jitter_auto     <= s_jitter_auto;
        end
        if (advance) begin
            out_res_reg <= step_res;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_send_now  = out_res_reg.send_now;
    assign m_send_kind = out_res_reg.send_kind;
    assign m_is_synced = out_res_reg.is_synced;

    // apb port, word aligned, zero wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg     <= NODE_ID_RESET;
            auto_period_reg <= AUTO_PERIOD_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_NODE_ID:     node_id_reg     <= pwdata[3:0];
                REG_AUTO_PERIOD: auto_period_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_NODE_ID:     prdata = {28'd0, node_id_reg};
            REG_AUTO_PERIOD: prdata = {16'd0, auto_period_reg};
            default:         prdata = '0;
        endcase
    end

endmodule

// ===== rtl/tdma_step.sv =====
// tdma_step: one millisecond tick of the scheduler, state in, next state and result out
// depends on tdma_pkg
module tdma_step import tdma_pkg::*; (
    input  logic [3:0]   node_id,
    input  logic [15:0]  auto_period_ms,
    input  sched_state_t cur,
    input  item_t        item,
    output sched_state_t nxt,
    output result_t      res
);

    logic [3:0]  eff_id;
    logic [19:0] offset;
    logic [20:0] slot_end;
    logic        fits;
    logic [16:0] sync_limit;
    logic [16:0] auto_limit;
    logic [17:0] loss_limit;
    send_kind_t  kind;
    sched_state_t adv;

    always_comb begin
        // out-of-range ids fall back to slot one
        if (node_id == 4'd0 || {4'd0, node_id} > NODE_ID_MAX) begin
            eff_id = 4'd1;
        end else begin
            eff_id = node_id;
        end

        // counters advance first, saturating
        adv = cur;
        if (cur.since_beacon != SINCE_BEACON_MAX) begin
            adv.since_beacon = cur.since_beacon + 18'd1;
        end
        if (cur.since_send != SINCE_SEND_MAX) begin
            adv.since_send = cur.since_send + 17'd1;
        end

        if (item.kind) begin
            adv.slot_len        = item.beacon_slot_ms;
            adv.cycle_len       = item.beacon_cycle_ms;
            adv.last_slot       = item.beacon_max_slot;
            adv.since_beacon    = '0;
            adv.synced          = 1'b1;
            adv.sent_this_cycle = 1'b0;
        end

        offset     = {16'd0, eff_id} * {4'd0, adv.slot_len};
        slot_end   = {1'b0, offset} + {5'd0, adv.slot_len};
        fits       = ({4'd0, eff_id} <= adv.last_slot) && (slot_end <= {5'd0, adv.cycle_len});
        sync_limit = {1'b0, adv.cycle_len} + {8'd0, item.jitter_sync};
        auto_limit = {1'b0, auto_period_ms} + {8'd0, item.jitter_auto};
        loss_limit = 18'(LOSS_CYCLES * {2'd0, adv.cycle_len});

        nxt  = adv;
        kind = KIND_NONE;
        if (adv.synced) begin
            if (fits) begin
                if (!adv.sent_this_cycle && {2'd0, adv.since_beacon} >= offset) begin
                    kind                = KIND_SLOT;
                    nxt.sent_this_cycle = 1'b1;
                end
            end else if (adv.since_send > sync_limit) begin
                kind           = KIND_OUT;
                nxt.since_send = '0;
            end
            if (adv.since_beacon > loss_limit) begin
                nxt.synced = 1'b0;
            end
        end else if (adv.since_send > auto_limit) begin
            kind           = KIND_AUTO;
            nxt.since_send = '0;
        end

        res.send_now  = (kind != KIND_NONE);
        res.send_kind = kind;
        res.is_synced = nxt.synced;
    end

endmodule

// ===== rtl/tdma_checker.sv =====
// tdma_checker: port-level assertions for tdma_slot_transmit_scheduler, bound to the top
// depends on tdma_pkg and tdma_slot_transmit_scheduler
module tdma_checker import tdma_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_send_now,
    input logic [1:0] m_send_kind,
    input logic       m_is_synced
);

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_send_now) && $stable(m_send_kind)
            && $stable(m_is_synced))
        else $error("result changed while stalled");

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // send flag agrees with send kind
    a_send_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_send_now == (m_send_kind != KIND_NONE))
        else $error("send_now disagrees with send_kind");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a request entering an empty pipe cannot be presented in the very next cycle
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && s_valid && s_ready && !$past(s_valid && s_ready) |=> !m_valid)
        else $error("result appeared too early");

endmodule

bind tdma_slot_transmit_scheduler tdma_checker u_tdma_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for tdma_slot_transmit_scheduler, one tick per request
// depends on tdma_pkg and the scheduler rtl; predicts every tick with its own scheduler copy
module testbench;
    import tdma_pkg::*;

    // register byte addresses, index taken from the package
    localparam logic [2:0] ADDR_NODE_ID     = {REG_NODE_ID, 2'b00};
    localparam logic [2:0] ADDR_AUTO_PERIOD = {REG_AUTO_PERIOD, 2'b00};

    // tick kinds on s_kind
    localparam logic TICK_PLAIN  = 1'b0;
    localparam logic TICK_BEACON = 1'b1;

    localparam int RANDOM_TICKS = 1800;
    localparam int PHASE_TICKS  = 250;
    localparam int STALL_LIMIT  = 3000;
    localparam int MAX_REPORTS  = 20;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid           = 1'b0;
    logic        s_ready;
    logic        s_kind            = 1'b0;
    logic [15:0] s_beacon_slot_ms  = '0;
    logic [15:0] s_beacon_cycle_ms = '0;
    logic [7:0]  s_beacon_max_slot = '0;
    logic [8:0]  s_jitter_sync     = '0;
    logic [8:0]  s_jitter_auto     = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_send_now;
    logic [1:0]  m_send_kind;
    logic        m_is_synced;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    tdma_slot_transmit_scheduler u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_kind            (s_kind),
        .s_beacon_slot_ms  (s_beacon_slot_ms),
        .s_beacon_cycle_ms (s_beacon_cycle_ms),
        .s_beacon_max_slot (s_beacon_max_slot),
        .s_jitter_sync     (s_jitter_sync),
        .s_jitter_auto     (s_jitter_auto),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_send_now        (m_send_now),
        .m_send_kind       (m_send_kind),
        .m_is_synced       (m_is_synced),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // scheduler copy: state, configuration and the queue of expected results
    sched_state_t sched           = '0;
    logic [3:0]   cfg_node_id     = NODE_ID_RESET;
    logic [15:0]  cfg_auto_period = AUTO_PERIOD_RESET;
    result_t      pending_results[$];

    int ticks_sent      = 0;
    int results_checked = 0;
    int errors          = 0;
    int sync_drops      = 0;
    int kind_count[4]   = '{0, 0, 0, 0};

    // traffic shaping: no_idle turns off sender gaps and receiver stalls
    logic no_idle    = 1'b0;
    int   burst_left = 0;
    int   rx_span    = 0;
    int   rx_hold    = 0;
    logic rx_choppy  = 1'b0;
    int   idle_cycles = 0;

    // one millisecond tick through the scheduler copy; order follows the block:
    // counters advance, beacon loads, send decision, then the sync-loss check
    function automatic result_t schedule_tick(input item_t it);
        result_t     r;
        logic [3:0]  id;
        logic        fits;
        int unsigned offset;
        int unsigned slot;
        int unsigned cycle;
        int unsigned elapsed_send;
        int unsigned elapsed_beacon;
        if (sched.since_beacon != SINCE_BEACON_MAX) sched.since_beacon = sched.since_beacon + 1'b1;
        if (sched.since_send != SINCE_SEND_MAX) sched.since_send = sched.since_send + 1'b1;
        if (it.kind == TICK_BEACON) begin
            sched.slot_len        = it.beacon_slot_ms;
            sched.cycle_len       = it.beacon_cycle_ms;
            sched.last_slot       = it.beacon_max_slot;
            sched.since_beacon    = '0;
            sched.synced          = 1'b1;
            sched.sent_this_cycle = 1'b0;
        end
        r.send_kind    = KIND_NONE;
        slot           = 32'(sched.slot_len);
        cycle          = 32'(sched.cycle_len);
        elapsed_send   = 32'(sched.since_send);
        elapsed_beacon = 32'(sched.since_beacon);
        if (sched.synced) begin
            // a node id of zero or beyond the maximum behaves as slot 1
            id = (cfg_node_id == 4'd0 || cfg_node_id > NODE_ID_MAX) ? 4'd1 : cfg_node_id;
            offset = id * slot;
            fits = (id <= sched.last_slot) && (offset + slot <= cycle);
            if (fits) begin
                if (!sched.sent_this_cycle && elapsed_beacon >= offset) begin
                    r.send_kind           = KIND_SLOT;
                    sched.sent_this_cycle = 1'b1;
                end
            end else if (elapsed_send > cycle + it.jitter_sync) begin
                r.send_kind      = KIND_OUT;
                sched.since_send = '0;
            end
            if (elapsed_beacon > LOSS_CYCLES * cycle) begin
                sched.synced = 1'b0;
                sync_drops++;
            end
        end else if (elapsed_send > cfg_auto_period + it.jitter_auto) begin
            r.send_kind      = KIND_AUTO;
            sched.since_send = '0;
        end
        r.send_now  = (r.send_kind != KIND_NONE);
        r.is_synced = sched.synced;
        kind_count[r.send_kind]++;
        return r;
    endfunction

    // sender: bursts of random length, random gaps between them
    task automatic push_tick(input item_t it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!no_idle && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid           <= 1'b1;
        s_kind            <= it.kind;
        s_beacon_slot_ms  <= it.beacon_slot_ms;
        s_beacon_cycle_ms <= it.beacon_cycle_ms;
        s_beacon_max_slot <= it.beacon_max_slot;
        s_jitter_sync     <= it.jitter_sync;
        s_jitter_auto     <= it.jitter_auto;
        do @(posedge aclk); while (!s_ready);
        // request taken at this edge: predict its result now
        pending_results.push_back(schedule_tick(it));
        ticks_sent++;
    endtask

    // plain tick: beacon fields carry random bits that the block must ignore
    function automatic item_t plain_tick(input int js, input int ja);
        item_t it;
        it.kind            = TICK_PLAIN;
        it.beacon_slot_ms  = 16'($urandom);
        it.beacon_cycle_ms = 16'($urandom);
        it.beacon_max_slot = 8'($urandom);
        it.jitter_sync     = 9'(js);
        it.jitter_auto     = 9'(ja);
        return it;
    endfunction

    function automatic item_t beacon_tick(input int slot, input int cycle, input int top_slot,
                                          input int js, input int ja);
        item_t it;
        it.kind            = TICK_BEACON;
        it.beacon_slot_ms  = 16'(slot);
        it.beacon_cycle_ms = 16'(cycle);
        it.beacon_max_slot = 8'(top_slot);
        it.jitter_sync     = 9'(js);
        it.jitter_auto     = 9'(ja);
        return it;
    endfunction

    // mostly small jitter so that jittered sends come often, full 9-bit range now and then
    function automatic int rand_jitter();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 20);
    endfunction

    task automatic run_ticks(input int n, input int js, input int ja);
        repeat (n) push_tick(plain_tick(js, ja));
    endtask

    // stop sending and wait until every predicted result is back, plus pipeline slack
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // apb transfer: setup cycle, then access cycle until pready
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        apb_access(1'b0, addr, 32'd0, got);
        if (got !== want) begin
            errors++;
            $display("%0t: register 0x%0h expected %0d, got %0d", $time, addr, want, got);
        end
    endtask

    // registers change only with the block idle; every write is read back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] ignored_rd;
        settle();
        apb_access(1'b1, addr, value, ignored_rd);
        if (addr == ADDR_NODE_ID) cfg_node_id = value[3:0];
        else cfg_auto_period = value[15:0];
        check_reg(addr, (addr == ADDR_NODE_ID) ? {28'd0, cfg_node_id} : {16'd0, cfg_auto_period});
    endtask

    // receiver: spans of steady acceptance alternate with spans of random stalls
    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_choppy = ($urandom_range(0, 2) != 0);
            rx_span   = $urandom_range(50, 400);
        end else begin
            rx_span--;
        end
        if (no_idle || !rx_choppy) begin
            m_ready <= 1'b1;
        end else if (rx_hold != 0) begin
            m_ready <= 1'b0;
            rx_hold--;
        end else if ($urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            rx_hold = $urandom_range(0, 25);
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic compare_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: result %0d %s expected %0d, got %0d",
                         $time, results_checked, name, want, got);
        end
    endtask

    // result checker: every accepted result against the oldest prediction
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with nothing expected, send_now %0d send_kind %0d",
                             $time, m_send_now, m_send_kind);
            end else begin
                want = pending_results.pop_front();
                compare_field("send_now", want.send_now, m_send_now);
                compare_field("send_kind", want.send_kind, m_send_kind);
                compare_field("is_synced", want.is_synced, m_is_synced);
            end
        end
    end

    // watchdog: too long without any request, result or register access
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reset values readable, nothing sent under the default long period
    task automatic test_register_defaults();
        check_reg(ADDR_NODE_ID, {28'd0, NODE_ID_RESET});
        check_reg(ADDR_AUTO_PERIOD, {16'd0, AUTO_PERIOD_RESET});
        run_ticks(3, 0, 0);
        settle();
    endtask

    // unsynced fallback: period zero sends on every tick, jitter stretches the wait
    task automatic test_autonomous_send();
        write_reg(ADDR_AUTO_PERIOD, 0);
        run_ticks(3, 0, 0);
        run_ticks(2, 0, 511);
        write_reg(ADDR_AUTO_PERIOD, 65535);
        run_ticks(2, 0, 0);
        write_reg(ADDR_AUTO_PERIOD, 4);
        run_ticks(12, 0, 3);
        settle();
    endtask

    // node 3 with 2 ms slots sends once, six ticks after the beacon
    task automatic test_own_slot();
        write_reg(ADDR_NODE_ID, 3);
        push_tick(beacon_tick(2, 40, 5, 0, 0));
        run_ticks(10, 0, 0);
        settle();
    endtask

    // node 15 beyond the highest slot: jittered out-of-cycle sends
    task automatic test_out_of_cycle();
        write_reg(ADDR_NODE_ID, 15);
        push_tick(beacon_tick(1, 4, 3, 0, 0));
        run_ticks(6, 0, 0);
        push_tick(beacon_tick(1, 4, 3, 511, 0));
        run_ticks(3, 511, 0);
        settle();
    endtask

    // 2 ms beacon cycle: sync drops once the time since the beacon exceeds LOSS_CYCLES times the cycle length
    task automatic test_sync_loss();
        write_reg(ADDR_NODE_ID, 1);
        write_reg(ADDR_AUTO_PERIOD, 2);
        push_tick(beacon_tick(1, 2, 255, 0, 0));
        run_ticks(9, 0, 1);
        settle();
    endtask

    // zero slot and cycle lengths, with and without room for the node
    task automatic test_zero_beacon();
        push_tick(beacon_tick(0, 0, 0, 0, 0));
        run_ticks(2, 0, 0);
        push_tick(beacon_tick(0, 0, 255, 0, 0));
        run_ticks(2, 0, 0);
        settle();
    endtask

    // node id zero must act as slot 1
    task automatic test_invalid_node_id();
        write_reg(ADDR_NODE_ID, 0);
        push_tick(beacon_tick(3, 30, 1, 0, 0));
        run_ticks(5, 0, 0);
        settle();
    endtask

    // own-slot sends never clear the send timer: after a run of own-slot timing,
    // a beacon that leaves no room must send right away, back to back throughout
    task automatic test_send_timer_kept();
        no_idle = 1'b1;
        write_reg(ADDR_NODE_ID, 1);
        push_tick(beacon_tick(1, 100, 255, 0, 0));
        run_ticks(60, 0, 0);
        push_tick(beacon_tick(1, 50, 0, 5, 0));
        run_ticks(2, 5, 0);
        settle();
        no_idle = 1'b0;
    endtask

    // random phases: mostly beacon cycles with random content, some noise and broken
    // sequences, and pauses until every result is back
    task automatic test_random_traffic();
        int phase;
        int start;
        int phase_start;
        int pick;
        int n;
        int cycle;
        phase = 0;
        start = ticks_sent;
        while (ticks_sent - start < RANDOM_TICKS) begin
            case (phase)
                0: begin
                    write_reg(ADDR_NODE_ID, 0);
                    write_reg(ADDR_AUTO_PERIOD, 0);
                end
                1: begin
                    write_reg(ADDR_NODE_ID, 15);
                    write_reg(ADDR_AUTO_PERIOD, 65535);
                end
                default: begin
                    write_reg(ADDR_NODE_ID, $urandom_range(0, 15));
                    write_reg(ADDR_AUTO_PERIOD, ($urandom_range(0, 4) == 0) ?
                              $urandom_range(0, 65535) : $urandom_range(0, 200));
                end
            endcase
            phase++;
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS && ticks_sent - start < RANDOM_TICKS) begin
                pick = $urandom_range(0, 19);
                if (pick < 14) begin
                    // well-formed cycle: beacon, then about one cycle of ticks,
                    // now and then long enough to lose sync
                    cycle = $urandom_range(8, 120);
                    push_tick(beacon_tick($urandom_range(1, 12), cycle,
                                          ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 20),
                                          rand_jitter(), rand_jitter()));
                    n = ($urandom_range(0, 5) == 0) ? 3 * cycle + $urandom_range(1, 40)
                                                    : $urandom_range(cycle / 2, cycle + 5);
                    repeat (n) push_tick(plain_tick(rand_jitter(), rand_jitter()));
                end else if (pick < 18) begin
                    // noise: full-range fields, occasional random beacon
                    repeat ($urandom_range(1, 6)) begin
                        push_tick(($urandom_range(0, 7) == 0) ?
                                  beacon_tick($urandom, $urandom, $urandom, $urandom, $urandom) :
                                  plain_tick($urandom_range(0, 511), $urandom_range(0, 511)));
                    end
                end else if (pick == 18) begin
                    // broken sequence: back-to-back beacons with short or empty cycles
                    repeat ($urandom_range(2, 4))
                        push_tick(beacon_tick($urandom_range(0, 3), $urandom_range(0, 6),
                                              $urandom_range(0, 3), rand_jitter(), rand_jitter()));
                    run_ticks($urandom_range(1, 10), rand_jitter(), rand_jitter());
                end else begin
                    // hold off until every expected result has arrived
                    settle();
                end
            end
        end
        settle();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        test_register_defaults();
        test_autonomous_send();
        test_own_slot();
        test_out_of_cycle();
        test_sync_loss();
        test_zero_beacon();
        test_invalid_node_id();
        test_send_timer_kept();
        test_random_traffic();

        $display("ticks %0d: own-slot %0d, out-of-cycle %0d, autonomous %0d sends, %0d sync losses",
                 ticks_sent, kind_count[KIND_SLOT], kind_count[KIND_OUT], kind_count[KIND_AUTO],
                 sync_drops);
        $display("results compared %0d, mismatches %0d", results_checked, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tdma_pkg.sv
rtl/tdma_step.sv
rtl/tdma_slot_transmit_scheduler.sv
rtl/tdma_checker.sv
test/testbench.sv
